>>> rtl/priority_round_robin_ready_queue_assert.svh
// Assertion macros used by the checker of the ready queue.
`ifndef PRIORITY_ROUND_ROBIN_READY_QUEUE_ASSERT_SVH
`define PRIORITY_ROUND_ROBIN_READY_QUEUE_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define PRRQ_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define PRRQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/prrq_pkg.sv
`timescale 1ns / 1ps
package prrq_pkg;

    localparam int DEF_NUM_LEVELS = 32;
    localparam int DEF_NUM_TASKS  = 32;

    localparam int OP_W        = 2;
    localparam int TASK_ID_W   = 5;
    localparam int PRIO_W      = 5;
    localparam int STATUS_W    = 2;
    localparam int CHOSEN_W    = 5;
    localparam int MAX_LEVELS  = 64;
    localparam int LEVEL_IDX_W = 6;

    typedef enum logic [OP_W-1:0] {
        OP_ADD     = 2'd0,
        OP_REMOVE  = 2'd1,
        OP_NEXT    = 2'd2,
        OP_RESTART = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_QUEUE_ERR = 2'd1,
        ST_EMPTY     = 2'd2
    } t_status;

    typedef struct packed {
        t_status             status;
        logic                preempt;
        logic [CHOSEN_W-1:0] chosen;
    } t_res;

    typedef logic [MAX_LEVELS-1:0] t_level_map;

    // Highest set bit of the level map, zero when the map is empty.
    function automatic logic [LEVEL_IDX_W-1:0] f_highest(input t_level_map map);
        logic [LEVEL_IDX_W-1:0] hi;
        hi = '0;
        for (int i = 0; i < MAX_LEVELS; i++) begin
            if (map[i]) begin
                hi = LEVEL_IDX_W'(i);
            end
        end
        return hi;
    endfunction

endpackage

>>> rtl/priority_round_robin_ready_queue.sv
`timescale 1ns / 1ps
// Ready queue for a real-time kernel: each priority level holds a circular
// doubly linked ring of task slots, kept in simple dual-port link memories
// (next, prev, slot level, level head) with a registered read, plus a
// level bitmap, a top-level register and a rotation pointer in flip-flops.
// One request is worked at a time and the input is stalled from acceptance
// until its result sits in the output register; that register lets the next
// request in while the result waits. Restart, rejected add or remove, next
// with nothing ready and add to an empty level go straight to the result;
// pick next, remove and add to a non-empty level pass through more states.
// Their work is set by the dependent reads and the one write per cycle
// on the next and prev memories. No clearing pass after reset: queued
// flags and the bitmap are flip-flops.
module priority_round_robin_ready_queue import prrq_pkg::*; #(
    parameter int NUM_LEVELS = DEF_NUM_LEVELS,
    parameter int NUM_TASKS  = DEF_NUM_TASKS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [OP_W-1:0]      i_op,
    input  logic [TASK_ID_W-1:0] i_task_id,
    input  logic [PRIO_W-1:0]    i_task_priority,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [STATUS_W-1:0]  o_status,
    output logic                 o_preempt,
    output logic [CHOSEN_W-1:0]  o_chosen_task
);

    localparam int TW = $clog2(NUM_TASKS);
    localparam int LW = $clog2(NUM_LEVELS);
    localparam int XW = ((TW > TASK_ID_W) ? TW : TASK_ID_W) + 1;
    localparam int PW = ((LW > PRIO_W) ? LW : PRIO_W) + 1;

    logic [XW-1:0] w_tid_x;
    logic          w_tid_ok;
    logic [PW-1:0] w_prio_x;
    logic [PW-1:0] w_lvl_x;
    logic          w_busy;
    logic          w_res_valid;
    logic          w_res_take;
    t_res          w_res;
    logic          r_ovalid;
    t_res          r_out;

    // range-check the slot and saturate the level
    assign w_tid_x  = XW'(i_task_id);
    assign w_tid_ok = (w_tid_x < XW'(NUM_TASKS));
    assign w_prio_x = PW'(i_task_priority);
    assign w_lvl_x  = (w_prio_x >= PW'(NUM_LEVELS)) ? PW'(NUM_LEVELS - 1) : w_prio_x;

    prrq_seq #(
        .NUM_LEVELS (NUM_LEVELS),
        .NUM_TASKS  (NUM_TASKS)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_valid && !o_stall),
        .i_op        (t_op'(i_op)),
        .i_tid       (w_tid_x[TW-1:0]),
        .i_tid_ok    (w_tid_ok),
        .i_lvl       (w_lvl_x[LW-1:0]),
        .o_busy      (w_busy),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .i_res_take  (w_res_take)
    );

    assign w_res_take = !r_ovalid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_res_valid && w_res_take) begin
            r_ovalid <= 1'b1;
        end else if (!i_stall) begin
            r_ovalid <= 1'b0;
        end
        if (w_res_valid && w_res_take) begin
            r_out <= w_res;
        end
    end

    assign o_stall       = w_busy || !i_rst_n;
    assign o_valid       = r_ovalid;
    assign o_status      = r_out.status;
    assign o_preempt     = r_out.preempt;
    assign o_chosen_task = r_out.chosen;

endmodule

>>> rtl/prrq_ram.sv
`timescale 1ns / 1ps
module prrq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/prrq_seq.sv
`timescale 1ns / 1ps
module prrq_seq import prrq_pkg::*; #(
    parameter int NUM_LEVELS = DEF_NUM_LEVELS,
    parameter int NUM_TASKS  = DEF_NUM_TASKS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_req_valid,
    input  t_op                           i_op,
    input  logic [$clog2(NUM_TASKS)-1:0]  i_tid,
    input  logic                          i_tid_ok,
    input  logic [$clog2(NUM_LEVELS)-1:0] i_lvl,
    output logic                          o_busy,
    output logic                          o_res_valid,
    output t_res                          o_res,
    input  logic                          i_res_take
);

    localparam int TW = $clog2(NUM_TASKS);
    localparam int LW = $clog2(NUM_LEVELS);

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD_H,
        S_ADD_T,
        S_ADD_L,
        S_REM,
        S_REM_H,
        S_TOP,
        S_NXT,
        S_FIN
    } t_state;

    t_state                  r_state, n_state;
    logic [NUM_TASKS-1:0]    r_queued, n_queued;
    logic [NUM_LEVELS-1:0]   r_map, n_map;
    logic [LW-1:0]           r_top, n_top;
    logic [TW-1:0]           r_rot, n_rot;
    logic                    r_rot_ok, n_rot_ok;
    logic [TW-1:0]           r_t, n_t;
    logic [LW-1:0]           r_lv, n_lv;
    logic [TW-1:0]           r_link, n_link;
    logic                    r_cand, n_cand;
    t_res                    r_res, n_res;

    logic                    prio_we;
    logic [TW-1:0]           prio_waddr, prio_raddr;
    logic [LW-1:0]           prio_wdata, prio_rdata;
    logic                    next_we;
    logic [TW-1:0]           next_waddr, next_wdata, next_raddr, next_rdata;
    logic                    prev_we;
    logic [TW-1:0]           prev_waddr, prev_wdata, prev_raddr, prev_rdata;
    logic                    head_we;
    logic [LW-1:0]           head_waddr, head_raddr;
    logic [TW-1:0]           head_wdata, head_rdata;

    logic [LEVEL_IDX_W-1:0]  w_hi;
    logic [TW-1:0]           w_pick;

    assign w_hi   = f_highest(t_level_map'(r_map));
    assign w_pick = (r_cand && (prio_rdata == r_top)) ? next_rdata : head_rdata;

    always_comb begin
        n_state  = r_state;
        n_queued = r_queued;
        n_map    = r_map;
        n_top    = r_top;
        n_rot    = r_rot;
        n_rot_ok = r_rot_ok;
        n_t      = r_t;
        n_lv     = r_lv;
        n_link   = r_link;
        n_cand   = r_cand;
        n_res    = r_res;

        prio_we    = 1'b0;
        prio_waddr = r_t;
        prio_wdata = r_lv;
        prio_raddr = r_rot;
        next_we    = 1'b0;
        next_waddr = r_t;
        next_wdata = r_t;
        next_raddr = r_rot;
        prev_we    = 1'b0;
        prev_waddr = r_t;
        prev_wdata = r_t;
        prev_raddr = r_rot;
        head_we    = 1'b0;
        head_waddr = r_lv;
        head_wdata = r_t;
        head_raddr = r_top;

        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_res = '0;
                    n_t   = i_tid;
                    n_lv  = i_lvl;
                    n_state = S_FIN;
                    case (i_op)
                        OP_ADD: begin
                            if (!i_tid_ok || r_queued[i_tid]) begin
                                n_res.status = ST_QUEUE_ERR;
                            end else begin
                                if (i_lvl > r_top) begin
                                    n_top         = i_lvl;
                                    n_rot_ok      = 1'b0;
                                    n_res.preempt = 1'b1;
                                end
                                n_queued[i_tid] = 1'b1;
                                prio_we    = 1'b1;
                                prio_waddr = i_tid;
                                prio_wdata = i_lvl;
                                if (r_map[i_lvl]) begin
                                    head_raddr = i_lvl;
                                    n_state    = S_ADD_H;
                                end else begin
                                    // first task of the level: a ring of one
                                    head_we      = 1'b1;
                                    head_waddr   = i_lvl;
                                    head_wdata   = i_tid;
                                    next_we      = 1'b1;
                                    next_waddr   = i_tid;
                                    next_wdata   = i_tid;
                                    prev_we      = 1'b1;
                                    prev_waddr   = i_tid;
                                    prev_wdata   = i_tid;
                                    n_map[i_lvl] = 1'b1;
                                end
                            end
                        end
                        OP_REMOVE: begin
                            if (!i_tid_ok || !r_queued[i_tid]) begin
                                n_res.status = ST_QUEUE_ERR;
                            end else begin
                                n_queued[i_tid] = 1'b0;
                                prio_raddr = i_tid;
                                next_raddr = i_tid;
                                prev_raddr = i_tid;
                                n_state    = S_REM;
                            end
                        end
                        OP_NEXT: begin
                            if (!r_map[r_top]) begin
                                n_res.status = ST_EMPTY;
                            end else begin
                                head_raddr = r_top;
                                prio_raddr = r_rot;
                                next_raddr = r_rot;
                                n_cand     = r_rot_ok && r_queued[r_rot];
                                n_state    = S_NXT;
                            end
                        end
                        OP_RESTART: begin
                            n_rot_ok = 1'b0;
                        end
                        default: begin
                            n_rot_ok = 1'b0;
                        end
                    endcase
                end
            end
            S_ADD_H: begin
                n_link     = head_rdata;
                prev_raddr = head_rdata;
                n_state    = S_ADD_T;
            end
            S_ADD_T: begin
                // tail now points forward to the new task
                next_we    = 1'b1;
                next_waddr = prev_rdata;
                next_wdata = r_t;
                prev_we    = 1'b1;
                prev_waddr = r_t;
                prev_wdata = prev_rdata;
                n_state    = S_ADD_L;
            end
            S_ADD_L: begin
                next_we    = 1'b1;
                next_waddr = r_t;
                next_wdata = r_link;
                prev_we    = 1'b1;
                prev_waddr = r_link;
                prev_wdata = r_t;
                n_state    = S_FIN;
            end
            S_REM: begin
                if (next_rdata == r_t) begin
                    n_map[prio_rdata] = 1'b0;
                    n_rot_ok          = 1'b0;
                    n_state           = S_TOP;
                end else begin
                    next_we    = 1'b1;
                    next_waddr = prev_rdata;
                    next_wdata = next_rdata;
                    prev_we    = 1'b1;
                    prev_waddr = next_rdata;
                    prev_wdata = prev_rdata;
                    n_link     = next_rdata;
                    n_lv       = prio_rdata;
                    head_raddr = prio_rdata;
                    n_state    = S_REM_H;
                end
            end
            S_REM_H: begin
                // advance the head past the removed task
                if (head_rdata == r_t) begin
                    head_we    = 1'b1;
                    head_waddr = r_lv;
                    head_wdata = r_link;
                end
                n_state = S_FIN;
            end
            S_TOP: begin
                n_top   = w_hi[LW-1:0];
                n_state = S_FIN;
            end
            S_NXT: begin
                n_rot        = w_pick;
                n_rot_ok     = 1'b1;
                n_res.chosen = CHOSEN_W'(w_pick);
                n_state      = S_FIN;
            end
            S_FIN: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_queued <= '0;
            r_map    <= '0;
            r_top    <= '0;
            r_rot    <= '0;
            r_rot_ok <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_queued <= n_queued;
            r_map    <= n_map;
            r_top    <= n_top;
            r_rot    <= n_rot;
            r_rot_ok <= n_rot_ok;
        end
        r_t    <= n_t;
        r_lv   <= n_lv;
        r_link <= n_link;
        r_cand <= n_cand;
        r_res  <= n_res;
    end

    prrq_ram #(.WIDTH(LW), .DEPTH(NUM_TASKS)) u_prio_ram (
        .i_clk   (i_clk),
        .i_we    (prio_we),
        .i_waddr (prio_waddr),
        .i_wdata (prio_wdata),
        .i_raddr (prio_raddr),
        .o_rdata (prio_rdata)
    );

    prrq_ram #(.WIDTH(TW), .DEPTH(NUM_TASKS)) u_next_ram (
        .i_clk   (i_clk),
        .i_we    (next_we),
        .i_waddr (next_waddr),
        .i_wdata (next_wdata),
        .i_raddr (next_raddr),
        .o_rdata (next_rdata)
    );

    prrq_ram #(.WIDTH(TW), .DEPTH(NUM_TASKS)) u_prev_ram (
        .i_clk   (i_clk),
        .i_we    (prev_we),
        .i_waddr (prev_waddr),
        .i_wdata (prev_wdata),
        .i_raddr (prev_raddr),
        .o_rdata (prev_rdata)
    );

    prrq_ram #(.WIDTH(TW), .DEPTH(NUM_LEVELS)) u_head_ram (
        .i_clk   (i_clk),
        .i_we    (head_we),
        .i_waddr (head_waddr),
        .i_wdata (head_wdata),
        .i_raddr (head_raddr),
        .o_rdata (head_rdata)
    );

    assign o_busy      = (r_state != S_IDLE);
    assign o_res_valid = (r_state == S_FIN);
    assign o_res       = r_res;

endmodule

>>> rtl/prrq_chk.sv
`timescale 1ns / 1ps
`include "priority_round_robin_ready_queue_assert.svh"
module prrq_chk import prrq_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_valid,
    input logic                 o_stall,
    input logic                 o_valid,
    input logic                 i_stall,
    input logic [STATUS_W-1:0]  o_status,
    input logic                 o_preempt,
    input logic [CHOSEN_W-1:0]  o_chosen_task
);

    // hold the result while the far side stalls
    `PRRQ_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n,
        o_valid && i_stall, o_valid, "result dropped under stall")

    // one request in flight: busy right after an accept
    `PRRQ_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n,
        i_valid && !o_stall, o_stall, "second request taken while busy")

    // a fresh result only comes out of a busy cycle
    `PRRQ_ASSERT_SAME(a_result_from_work, i_clk, i_rst_n,
        $rose(o_valid), $past(o_stall), "result without a request")

    // failures and preemption carry no chosen task
    `PRRQ_ASSERT_SAME(a_clean_fields, i_clk, i_rst_n,
        o_valid && (o_status != ST_OK || o_preempt), o_chosen_task == '0,
        "chosen task on a non-pick result")

endmodule

bind priority_round_robin_ready_queue prrq_chk u_prrq_chk (.*);
